@@ rtl/irvts_pkg.sv @@
// ----------------------------------------------------------------------------
// irvts_pkg: shared types and constants of the infusion solver
// Field widths, reciprocal constants, the syringe rate limit table and the
// word that travels down the divider chain.
// ----------------------------------------------------------------------------
package irvts_pkg;

  localparam int RATE_W = 14;
  localparam int VOL_W  = 17;
  localparam int HHMM_W = 14;
  localparam int MIN_W  = 14;
  localparam int LIM_W  = 14;
  localparam int RES_W  = 21;
  localparam int SYR_W  = 3;

  // dividend and divisor widths of the divider chain
  localparam int NUM_W  = 28;
  localparam int DEN_W  = 14;

  localparam logic [5:0]        MIN_PER_HR      = 6'd60;
  localparam logic [6:0]        HHMM_RADIX      = 7'd100;
  localparam logic [RES_W-1:0]  VOL_ERR_LIMIT   = RES_W'(100000);
  localparam logic [RES_W-1:0]  TIME_MAX_PACKED = RES_W'(9959);
  localparam logic [RES_W-1:0]  RESULT_MAX      = {RES_W{1'b1}};
  // solved minutes at or above this pack to more than 99:59
  localparam logic [NUM_W-1:0]  TIME_CLAMP_MINS = NUM_W'(6000);

  // x / 100 = (x * 5243) >> 19, exact for x below 2^14
  localparam logic [12:0]       RECIP100    = 13'd5243;
  localparam int                RECIP100_SH = 19;
  // x / 60 = (x * 17477) >> 20, exact for x below 6000
  localparam logic [14:0]       RECIP60     = 15'd17477;
  localparam int                RECIP60_SH  = 20;

  typedef enum logic [1:0] {
    OP_RATE   = 2'd0,
    OP_VOLUME = 2'd1,
    OP_TIME   = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [LIM_W-1:0] lim;
    logic             zero_div;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;   // dividend bits still to go, quotient shifts in
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    side_t            side;
  } divw_t;

  function automatic logic [LIM_W-1:0] rate_limit(input logic [SYR_W-1:0] sel);
    logic [LIM_W-1:0] lim;
    case (sel)
      3'd0:    lim = LIM_W'(0);
      3'd1:    lim = LIM_W'(1800);
      3'd2:    lim = LIM_W'(3500);
      3'd3:    lim = LIM_W'(5000);
      3'd4:    lim = LIM_W'(9000);
      default: lim = LIM_W'(12000);
    endcase
    return lim;
  endfunction

endpackage

@@ rtl/infusion_rate_volume_time_solver_top.sv @@
// ----------------------------------------------------------------------------
// infusion_rate_volume_time_solver_top: solve rate, volume or time
// Streaming solver for the third infusion quantity from the other two.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions on s_axis carry rate, volume and packed hh:mm time in
//   tdata and the mode in tuser (0 rate, 1 volume, 2 or 3 time). Each one
//   yields exactly one output transaction on m_axis: the solved value in
//   tdata and the error flag in tuser.
//   cfg_wr_en / cfg_wr_data write the syringe size selecting the rate limit;
//   write it only while no transaction is in flight.
//   From input to output a transaction passes three operand stages, a row
//   of 28 restoring-division cells (one quotient bit per cell) and two
//   result stages. One transaction is taken per cycle when m_axis_tready
//   stays high.
//   Reset clears every stage's valid bit and the syringe size to 0.
//   When the receiver stalls, the output register holds its transaction and
//   the pipeline keeps taking input until every stage is occupied; each
//   stage's ready is its own emptiness or the ready of the stage after it.
// ----------------------------------------------------------------------------
module infusion_rate_volume_time_solver_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [irvts_pkg::SYR_W-1:0]       cfg_wr_data,   // syringe_size
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // rate [13:0], volume [30:14], packed_time [44:31], zero [47:45]
  input  logic [47:0]                       s_axis_tdata,
  // op [1:0]
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // result_value [20:0], zero [23:21]
  output logic [23:0]                       m_axis_tdata,
  // error [0]
  output logic [0:0]                        m_axis_tuser
);
  import irvts_pkg::*;

  logic [SYR_W-1:0] syringe_size;

  logic  cell_vld [0:NUM_W];
  logic  cell_rdy [0:NUM_W];
  divw_t cell_dat [0:NUM_W];

  logic [RES_W-1:0] result_value;
  logic             error;

  always_ff @(posedge clk) begin
    if (rst) begin
      syringe_size <= '0;
    end else if (cfg_wr_en) begin
      syringe_size <= cfg_wr_data;
    end
  end

  irvts_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .syringe_size (syringe_size),
    .up_valid     (s_axis_tvalid),
    .up_ready     (s_axis_tready),
    .op           (op_t'(s_axis_tuser)),
    .rate         (s_axis_tdata[13:0]),
    .volume       (s_axis_tdata[30:14]),
    .packed_time  (s_axis_tdata[44:31]),
    .dn_valid     (cell_vld[0]),
    .dn_ready     (cell_rdy[0]),
    .dn_data      (cell_dat[0])
  );

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    irvts_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (cell_vld[i]),
      .up_ready (cell_rdy[i]),
      .up_data  (cell_dat[i]),
      .dn_valid (cell_vld[i+1]),
      .dn_ready (cell_rdy[i+1]),
      .dn_data  (cell_dat[i+1])
    );
  end

  irvts_post u_post (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (cell_vld[NUM_W]),
    .up_ready     (cell_rdy[NUM_W]),
    .up_data      (cell_dat[NUM_W]),
    .dn_valid     (m_axis_tvalid),
    .dn_ready     (m_axis_tready),
    .result_value (result_value),
    .error        (error)
  );

  assign m_axis_tdata = {3'b000, result_value};
  assign m_axis_tuser = error;

  // an empty output register means every stage can take a transaction
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with the output register empty");

  // the last cell must leave a remainder below any non-zero divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    cell_vld[NUM_W] && cell_dat[NUM_W].den != '0 |->
      cell_dat[NUM_W].rem < cell_dat[NUM_W].den)
    else $error("division remainder not below divisor");

  // flagged results are either the clamped time or an oversized volume
  a_error_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] && result_value != TIME_MAX_PACKED |->
      result_value > VOL_ERR_LIMIT)
    else $error("error flag on an in-range result");

endmodule

@@ rtl/irvts_prep.sv @@
// ----------------------------------------------------------------------------
// irvts_prep: operand stages ahead of the divider chain
// Converts packed hh:mm to minutes and forms dividend, divisor and the
// zero-divisor flag for the selected mode, over three registered stages.
// ----------------------------------------------------------------------------
module irvts_prep (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [irvts_pkg::SYR_W-1:0]       syringe_size,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  irvts_pkg::op_t                    op,
  input  logic [irvts_pkg::RATE_W-1:0]      rate,
  input  logic [irvts_pkg::VOL_W-1:0]       volume,
  input  logic [irvts_pkg::HHMM_W-1:0]      packed_time,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output irvts_pkg::divw_t                  dn_data
);
  import irvts_pkg::*;

  logic v0, v1, v2;
  logic r0, r1, r2;

  op_t               op0, op1;
  logic [RATE_W-1:0] rate0, rate1;
  logic [VOL_W-1:0]  vol0, vol1;
  logic [HHMM_W-1:0] hhmm0;
  logic [7:0]        hh0;
  logic [MIN_W-1:0]  mins1;
  logic [LIM_W-1:0]  lim1;
  divw_t             data2;

  logic [HHMM_W+12:0] hh_prod;
  logic [HHMM_W-1:0]  mm_wide;
  logic [MIN_W-1:0]   mins_next;
  logic [NUM_W-1:0]   vol60;
  logic [NUM_W-1:0]   rate_mins;
  divw_t              data2_next;

  assign r2       = !v2 || dn_ready;
  assign r1       = !v1 || r2;
  assign r0       = !v0 || r1;
  assign up_ready = r0;
  assign dn_valid = v2;
  assign dn_data  = data2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (r0) v0 <= up_valid;
      if (r1) v1 <= v0;
      if (r2) v2 <= v1;
    end
  end

  // hours digit pair by reciprocal multiply
  assign hh_prod = (HHMM_W+13)'(packed_time) * (HHMM_W+13)'(RECIP100);

  always_ff @(posedge clk) begin
    if (r0 && up_valid) begin
      op0   <= op;
      rate0 <= rate;
      vol0  <= volume;
      hhmm0 <= packed_time;
      hh0   <= hh_prod[HHMM_W+12:RECIP100_SH];
    end
  end

  always_comb begin
    mm_wide   = hhmm0 - HHMM_W'(hh0) * HHMM_W'(HHMM_RADIX);
    mins_next = MIN_W'(hh0) * MIN_W'(MIN_PER_HR) + MIN_W'(mm_wide[6:0]);
  end

  always_ff @(posedge clk) begin
    if (r1 && v0) begin
      op1   <= op0;
      rate1 <= rate0;
      vol1  <= vol0;
      mins1 <= mins_next;
      lim1  <= rate_limit(syringe_size);
    end
  end

  always_comb begin
    vol60     = NUM_W'(vol1) * NUM_W'(MIN_PER_HR);
    rate_mins = NUM_W'(rate1) * NUM_W'(mins1);
    data2_next          = '0;
    data2_next.side.op  = op1;
    data2_next.side.lim = lim1;
    // bias the dividend by divisor minus one to round the quotient up
    case (op1)
      OP_RATE: begin
        data2_next.num           = vol60 + NUM_W'(mins1) - NUM_W'(1);
        data2_next.den           = DEN_W'(mins1);
        data2_next.side.zero_div = (mins1 == '0);
      end
      OP_VOLUME: begin
        data2_next.num           = rate_mins + NUM_W'(MIN_PER_HR) - NUM_W'(1);
        data2_next.den           = DEN_W'(MIN_PER_HR);
        data2_next.side.zero_div = 1'b0;
      end
      default: begin
        data2_next.num           = vol60 + NUM_W'(rate1) - NUM_W'(1);
        data2_next.den           = DEN_W'(rate1);
        data2_next.side.zero_div = (rate1 == '0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      data2 <= data2_next;
    end
  end

endmodule

@@ rtl/irvts_cell.sv @@
// ----------------------------------------------------------------------------
// irvts_cell: one restoring division step
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module irvts_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  irvts_pkg::divw_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output irvts_pkg::divw_t dn_data
);
  import irvts_pkg::*;

  logic       vld;
  divw_t      data, data_next;
  logic [DEN_W:0] rem_sh, diff;

  always_comb begin
    rem_sh    = {up_data.rem, up_data.num[NUM_W-1]};
    diff      = rem_sh - {1'b0, up_data.den};
    data_next = up_data;
    if (rem_sh >= {1'b0, up_data.den}) begin
      data_next.rem = diff[DEN_W-1:0];
      data_next.num = {up_data.num[NUM_W-2:0], 1'b1};
    end else begin
      data_next.rem = rem_sh[DEN_W-1:0];
      data_next.num = {up_data.num[NUM_W-2:0], 1'b0};
    end
  end

  assign up_ready = !vld || dn_ready;
  assign dn_valid = vld;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

@@ rtl/irvts_post.sv @@
// ----------------------------------------------------------------------------
// irvts_post: result stages behind the divider chain
// Applies the syringe limit, the volume error flag, or the repack of
// minutes to hh:mm with the 99:59 clamp, and holds the output register.
// ----------------------------------------------------------------------------
module irvts_post (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  irvts_pkg::divw_t             up_data,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic [irvts_pkg::RES_W-1:0]  result_value,
  output logic                         error
);
  import irvts_pkg::*;

  logic v0, v1;
  logic r0, r1;

  logic [NUM_W-1:0]  quo0;
  side_t             side0;
  logic [27:0]       hh_prod0;

  logic [RES_W-1:0]  res, res_next;
  logic              err, err_next;
  logic [6:0]        hh;
  logic [12:0]       mm_wide;

  assign r1       = !v1 || dn_ready;
  assign r0       = !v0 || r1;
  assign up_ready = r0;
  assign dn_valid = v1;
  assign result_value = res;
  assign error        = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (r0) v0 <= up_valid;
      if (r1) v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (r0 && up_valid) begin
      quo0     <= up_data.num;
      side0    <= up_data.side;
      hh_prod0 <= 28'(up_data.num[12:0]) * 28'(RECIP60);
    end
  end

  always_comb begin
    hh       = hh_prod0[RECIP60_SH+6:RECIP60_SH];
    mm_wide  = quo0[12:0] - 13'(hh) * 13'(MIN_PER_HR);
    res_next = '0;
    err_next = 1'b0;
    case (side0.op)
      OP_RATE: begin
        if (side0.zero_div || quo0 > NUM_W'(side0.lim)) begin
          res_next = RES_W'(side0.lim);
        end else begin
          res_next = quo0[RES_W-1:0];
        end
      end
      OP_VOLUME: begin
        err_next = (quo0 > NUM_W'(VOL_ERR_LIMIT));
        if (quo0 > NUM_W'(RESULT_MAX)) begin
          res_next = RESULT_MAX;
        end else begin
          res_next = quo0[RES_W-1:0];
        end
      end
      default: begin
        if (side0.zero_div || quo0 >= TIME_CLAMP_MINS) begin
          res_next = TIME_MAX_PACKED;
          err_next = 1'b1;
        end else begin
          res_next = RES_W'(hh) * RES_W'(HHMM_RADIX) + RES_W'(mm_wide[5:0]);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (r1 && v0) begin
      res <= res_next;
      err <= err_next;
    end
  end

endmodule

@@ tb/sv/infusion_solver_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infusion_solver_checker: prediction and comparison for the infusion solver
// Watches the syringe size writes and both stream channels. Every accepted
// input transaction is solved here and queued; every output transaction is
// compared field by field with the oldest solution waiting.
// ----------------------------------------------------------------------------
module infusion_solver_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [irvts_pkg::SYR_W-1:0]  cfg_wr_data,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [47:0]                  s_axis_tdata,
  input  logic [1:0]                   s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [23:0]                  m_axis_tdata,
  input  logic [0:0]                   m_axis_tuser,
  output int                           fail_count,
  output int                           pending
);
  import irvts_pkg::*;

  typedef struct packed {
    logic [RES_W-1:0] value;
    logic             err;
  } solved_t;

  solved_t          solved_q[$];
  logic [SYR_W-1:0] syringe_sel;

  function automatic solved_t solve_infusion(input op_t op,
                                             input logic [RATE_W-1:0] rate,
                                             input logic [VOL_W-1:0]  vol,
                                             input logic [HHMM_W-1:0] hhmm,
                                             input logic [SYR_W-1:0]  syr);
    longint unsigned r, v, t, mins, cap, q, m;
    solved_t s;
    r = rate;
    v = vol;
    t = hhmm;
    // minute digits above 59 count as given
    mins = (t / HHMM_RADIX) * MIN_PER_HR + t % HHMM_RADIX;
    case (syr)
      3'd0:    cap = 0;
      3'd1:    cap = 1800;
      3'd2:    cap = 3500;
      3'd3:    cap = 5000;
      3'd4:    cap = 9000;
      default: cap = 12000;
    endcase
    s.err = 1'b0;
    case (op)
      OP_RATE: begin
        if (mins == 0) begin
          q = cap;
        end else begin
          q = (v * MIN_PER_HR + mins - 1) / mins;
          if (q > cap) q = cap;
        end
      end
      OP_VOLUME: begin
        q = (r * mins + MIN_PER_HR - 1) / MIN_PER_HR;
        if (q > VOL_ERR_LIMIT) s.err = 1'b1;
        if (q > RESULT_MAX) q = RESULT_MAX;
      end
      default: begin
        // the spare selector solves for time as well
        if (r == 0) begin
          q = TIME_MAX_PACKED;
          s.err = 1'b1;
        end else begin
          m = (v * MIN_PER_HR + r - 1) / r;
          q = (m / MIN_PER_HR) * HHMM_RADIX + m % MIN_PER_HR;
          if (q > TIME_MAX_PACKED) begin
            q = TIME_MAX_PACKED;
            s.err = 1'b1;
          end
        end
      end
    endcase
    s.value = RES_W'(q);
    return s;
  endfunction

  task automatic flag_failure(input string why, input solved_t want, input solved_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] %s: expected value %0d error %0b, got value %0d error %0b",
               $time, why, want.value, want.err, got.value, got.err);
  endtask

  always @(posedge clk) begin
    solved_t got, want;
    if (rst) begin
      syringe_sel = '0;
      solved_q.delete();
      fail_count = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        solved_q.push_back(solve_infusion(op_t'(s_axis_tuser),
                                          s_axis_tdata[13:0],
                                          s_axis_tdata[30:14],
                                          s_axis_tdata[44:31],
                                          syringe_sel));
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata[RES_W-1:0];
        got.err   = m_axis_tuser[0];
        if (solved_q.size() == 0) begin
          flag_failure("unexpected result", '0, got);
        end else begin
          want = solved_q.pop_front();
          if (got.value !== want.value || got.err !== want.err)
            flag_failure("result mismatch", want, got);
        end
      end
      // writes only land while idle, so order against the queue does not matter
      if (cfg_wr_en) syringe_sel = cfg_wr_data;
    end
    pending <= solved_q.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the infusion rate, volume and time solver
// Directed corner transactions, then random phases over every syringe size,
// with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
  import irvts_pkg::*;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              cfg_wr_en     = 1'b0;
  logic [SYR_W-1:0]  cfg_wr_data   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [47:0]       s_axis_tdata  = '0;   // rate, volume, packed_time, zero
  logic [1:0]        s_axis_tuser  = '0;   // op
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;         // result_value, zero
  logic [0:0]        m_axis_tuser;         // error

  int fail_count;
  int pending;
  bit no_gaps;

  always #10 clk = ~clk;

  infusion_rate_volume_time_solver_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  infusion_solver_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // present one transaction, hold it until taken, then draw the gap after it
  task automatic send_solve(input op_t op, input int rate, input int vol, input int hhmm);
    int gap;
    s_axis_tuser  = op;
    s_axis_tdata  = {3'b000, HHMM_W'(hhmm), VOL_W'(vol), RATE_W'(rate)};
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // write the syringe size only once nothing is in flight
  task automatic write_syringe(input int size);
    drain();
    cfg_wr_data = SYR_W'(size);
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  task automatic send_random;
    op_t op;
    int  pick, rate, vol, hhmm;
    pick = $urandom_range(0, 15);
    if (pick < 5)       op = OP_RATE;
    else if (pick < 10) op = OP_VOLUME;
    else if (pick < 15) op = OP_TIME;
    else                op = OP_SPARE;
    case ($urandom_range(0, 7))
      0:       rate = 0;
      1:       rate = $urandom_range(0, 16383);
      2:       rate = $urandom_range(1, 100);
      default: rate = $urandom_range(1, 12000);
    endcase
    case ($urandom_range(0, 7))
      0:       vol = 0;
      1:       vol = $urandom_range(0, 131071);
      2:       vol = $urandom_range(0, 2000);
      default: vol = $urandom_range(0, 99999);
    endcase
    case ($urandom_range(0, 7))
      0:       hhmm = 0;
      1:       hhmm = $urandom_range(0, 16383);
      2:       hhmm = $urandom_range(0, 99) * 100 + $urandom_range(0, 99);
      3:       hhmm = $urandom_range(0, 59);
      default: hhmm = $urandom_range(0, 99) * 100 + $urandom_range(0, 59);
    endcase
    send_solve(op, rate, vol, hhmm);
  endtask

  // receiver: stall a random number of cycles before each transaction
  initial begin
    int stall;
    int taken = 0;
    bit calm  = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
      taken++;
    end
  end

  initial begin
    #5_000_000;
    $display("infusion_rate_volume_time_solver_top regression: fail");
    $finish;
  end

  initial begin
    int sizes[10];
    sizes = '{0, 1, 7, 2, 3, 4, 5, 6, 0, 7};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    write_syringe(6);
    // rate: clamp, zero volume, zero minutes, full width, minute digits above 59
    send_solve(OP_RATE, 0, 99999, 1);
    send_solve(OP_RATE, 500, 0, 100);
    send_solve(OP_RATE, 16383, 700, 0);
    send_solve(OP_RATE, 0, 131071, 16383);
    send_solve(OP_RATE, 1, 1, 9959);
    send_solve(OP_RATE, 9, 100, 199);
    // volume: error threshold, saturation, rounding up
    send_solve(OP_VOLUME, 12000, 0, 9959);
    send_solve(OP_VOLUME, 16383, 131071, 16383);
    send_solve(OP_VOLUME, 0, 5, 9959);
    send_solve(OP_VOLUME, 1, 0, 1);
    send_solve(OP_VOLUME, 1000, 0, 6000);
    send_solve(OP_VOLUME, 10000, 0, 1000);
    send_solve(OP_VOLUME, 10001, 0, 1000);
    // time: zero rate, clamp and the edge just below it, spare selector
    send_solve(OP_TIME, 0, 500, 0);
    send_solve(OP_TIME, 12000, 0, 1234);
    send_solve(OP_TIME, 1, 99999, 0);
    send_solve(OP_TIME, 16383, 131071, 16383);
    send_solve(OP_TIME, 600, 5999, 0);
    send_solve(OP_TIME, 60, 5999, 0);
    send_solve(OP_TIME, 60, 6000, 0);
    send_solve(OP_SPARE, 120, 200, 9999);
    send_solve(OP_SPARE, 0, 131071, 0);

    foreach (sizes[p]) begin
      write_syringe(sizes[p]);
      for (int i = 0; i < 125; i++) begin
        if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_random();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("infusion_rate_volume_time_solver_top regression: pass");
    else
      $display("infusion_rate_volume_time_solver_top regression: fail");
    $finish;
  end

endmodule
